### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define FRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define FRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Types, widths and codes shared by the frame ring allocator files.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int RING_W         = 25;
  localparam int OFS_W          = 24;
  localparam int FIF_W          = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int FRA_MAX_FRAMES = 4;
  localparam int Q_DEPTH        = 4;
  localparam int Q_PTR_W        = 2;
  localparam int Q_CNT_W        = 3;

  localparam logic [RING_W-1:0] RING_RESET = 25'd65536;
  localparam logic [RING_W-1:0] RING_MAX   = 25'h1000000;
  localparam logic [FIF_W-1:0]  FIF_RESET  = 3'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COHERENT  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_EOF   = 1'b1;
  localparam logic RES_ALLOC  = 1'b0;
  localparam logic RES_FLUSH  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [RING_W-1:0] request_size;
  } fra_in_t;

  typedef struct packed {
    logic              result_kind;
    logic              granted;
    logic [OFS_W-1:0]  start_offset;
    logic [RING_W-1:0] range_length;
    logic              flush_needed;
    logic              ring_idle;
    logic              last;
  } fra_out_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [RING_W-1:0]    data;
  } fra_cfg_wr_t;

  typedef struct packed {
    logic     en;
    logic     two;
    fra_out_t first;
    fra_out_t second;
  } fra_push_t;

endpackage

### rtl/fra_ifs.sv
// ----------------------------------------------------------------------------
// fra_ifs
// Valid/ready channel interfaces of the frame ring allocator.
// ----------------------------------------------------------------------------
interface fra_in_if import fra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [RING_W-1:0] request_size;

  modport source (output valid, kind, request_size, input ready);
  modport sink   (input valid, kind, request_size, output ready);
endinterface

interface fra_out_if import fra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic              granted;
  logic [OFS_W-1:0]  start_offset;
  logic [RING_W-1:0] range_length;
  logic              flush_needed;
  logic              ring_idle;
  logic              last;

  modport source (output valid, result_kind, granted, start_offset, range_length,
                  flush_needed, ring_idle, last, input ready);
  modport sink   (input valid, result_kind, granted, start_offset, range_length,
                  flush_needed, ring_idle, last, output ready);
endinterface

interface fra_cfg_if import fra_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RING_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fra_engine.sv
// ----------------------------------------------------------------------------
// fra_engine
// Configuration registers, allocator state and the combinational update that
// turns one registered item into one or two results.
// ----------------------------------------------------------------------------
module fra_engine import fra_pkg::*; #(
  parameter int MAX_FRAMES = FRA_MAX_FRAMES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fra_cfg_wr_t cfg_wr,
  input  fra_in_t     item,
  input  logic        issue,
  output fra_push_t   push
);

  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RST_FRAMES = (int'(FIF_RESET) > MAX_FRAMES) ? MAX_FRAMES : int'(FIF_RESET);
  localparam int RST_OLDEST = (RST_FRAMES < 1) ? 0 : RST_FRAMES - 1;

  logic [RING_W-1:0] sz_r;
  logic [IDX_W-1:0]  oldest_r;
  logic              coherent_r;

  logic [RING_W-1:0] wo_r, wo_nxt;
  logic [RING_W-1:0] bf_r, bf_nxt;
  logic [RING_W-1:0] fs_r, fs_nxt;
  logic [RING_W-1:0] hist_r   [MAX_FRAMES];
  logic [RING_W-1:0] hist_nxt [MAX_FRAMES];

  logic [RING_W-1:0] sz_wr;
  logic [IDX_W-1:0]  oldest_wr;
  logic [FIF_W-1:0]  fif_wr;

  logic [RING_W-1:0] req;
  logic [RING_W-1:0] tail;
  logic [RING_W:0]   wo_plus_req;
  logic              over;
  logic [RING_W-1:0] bf_w;
  logic [RING_W-1:0] used;
  logic              two;
  logic [RING_W:0]   wrap_st;
  logic [RING_W-1:0] r0s;
  logic [RING_W-1:0] r0s_c;
  logic [RING_W:0]   rel_sum;
  logic [RING_W-1:0] bf_eof;
  fra_out_t          first, second;

  always_comb begin
    if (cfg_wr.data == '0) begin
      sz_wr = RING_W'(1);
    end else if (cfg_wr.data > RING_MAX) begin
      sz_wr = RING_MAX;
    end else begin
      sz_wr = cfg_wr.data;
    end
    fif_wr = cfg_wr.data[FIF_W-1:0];
    if (fif_wr == '0) begin
      oldest_wr = '0;
    end else if (int'(fif_wr) > MAX_FRAMES) begin
      oldest_wr = IDX_W'(MAX_FRAMES - 1);
    end else begin
      oldest_wr = IDX_W'(int'(fif_wr) - 1);
    end
  end

  always_comb begin
    req         = item.request_size;
    tail        = sz_r - wo_r;
    wo_plus_req = {1'b0, wo_r} + {1'b0, req};
    over        = wo_plus_req > {1'b0, sz_r};
    bf_w        = (bf_r > tail) ? (bf_r - tail) : '0;
    used        = (fs_r > bf_r) ? (fs_r - bf_r) : '0;
    two         = used > wo_r;
    wrap_st     = {1'b0, wo_r} + {1'b0, sz_r} - {1'b0, used};
    r0s         = two ? wrap_st[RING_W-1:0] : (wo_r - used);
    r0s_c       = (r0s >= sz_r) ? '0 : r0s;
    rel_sum     = {1'b0, bf_r} + {1'b0, hist_r[oldest_r]};
    bf_eof      = (rel_sum > {1'b0, sz_r}) ? sz_r : rel_sum[RING_W-1:0];

    wo_nxt   = wo_r;
    bf_nxt   = bf_r;
    fs_nxt   = fs_r;
    hist_nxt = hist_r;
    first    = '0;
    second   = '0;
    first.last = 1'b1;

    if (item.kind == KIND_ALLOC) begin
      first.result_kind = RES_ALLOC;
      if (bf_r < req) begin
        first.granted = 1'b0;
      end else if (over) begin
        wo_nxt = '0;
        if (bf_w < req) begin
          bf_nxt        = bf_w;
          first.granted = 1'b0;
        end else begin
          wo_nxt        = req;
          bf_nxt        = bf_w - req;
          first.granted = 1'b1;
        end
      end else begin
        wo_nxt             = wo_plus_req[RING_W-1:0];
        bf_nxt             = bf_r - req;
        first.granted      = 1'b1;
        first.start_offset = (wo_r >= sz_r) ? '0 : wo_r[OFS_W-1:0];
      end
    end else begin
      bf_nxt      = bf_eof;
      fs_nxt      = bf_eof;
      hist_nxt[0] = used;
      for (int i = 1; i < MAX_FRAMES; i++) begin
        if (i <= int'(oldest_r)) begin
          hist_nxt[i] = hist_r[i-1];
        end
      end
      first.result_kind   = RES_FLUSH;
      first.start_offset  = r0s_c[OFS_W-1:0];
      first.range_length  = two ? (used - wo_r) : used;
      first.flush_needed  = ~coherent_r;
      first.last          = ~two;
      second.result_kind  = RES_FLUSH;
      second.range_length = wo_r;
      second.flush_needed = ~coherent_r;
      second.last         = 1'b1;
    end

    first.ring_idle  = (bf_nxt == sz_r);
    second.ring_idle = (bf_nxt == sz_r);

    push.en     = issue;
    push.two    = (item.kind == KIND_EOF) && two;
    push.first  = first;
    push.second = second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sz_r       <= RING_RESET;
      oldest_r   <= IDX_W'(RST_OLDEST);
      coherent_r <= 1'b0;
      wo_r       <= '0;
      bf_r       <= RING_RESET;
      fs_r       <= RING_RESET;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        hist_r[i] <= '0;
      end
    end else if (cfg_wr.en && cfg_wr.index == REG_RING_SIZE) begin
      sz_r <= sz_wr;
      wo_r <= '0;
      bf_r <= sz_wr;
      fs_r <= sz_wr;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_wr.en) begin
        unique case (cfg_wr.index)
          REG_FRAMES:   oldest_r   <= oldest_wr;
          REG_COHERENT: coherent_r <= cfg_wr.data[0];
          default: ;
        endcase
      end
      if (issue) begin
        wo_r   <= wo_nxt;
        bf_r   <= bf_nxt;
        fs_r   <= fs_nxt;
        hist_r <= hist_nxt;
      end
    end
  end

endmodule

### rtl/fra_outq.sv
// ----------------------------------------------------------------------------
// fra_outq
// Four-entry result queue that takes one or two results per cycle and
// presents one result per transfer on the output channel.
// ----------------------------------------------------------------------------
module fra_outq import fra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fra_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output fra_out_t  out_data
);

  fra_out_t            q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic [Q_CNT_W-1:0]  n_push;
  logic                pop;
  logic [Q_PTR_W-1:0]  wr_ptr_1;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (int'(count_r) <= Q_DEPTH - 2);
  assign wr_ptr_1  = wr_ptr_r + Q_PTR_W'(1);

  always_comb begin
    if (!push.en) begin
      n_push = '0;
    end else if (push.two) begin
      n_push = Q_CNT_W'(2);
    end else begin
      n_push = Q_CNT_W'(1);
    end
    count_nxt = count_r + n_push - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push[Q_PTR_W-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.en) begin
      q_r[wr_ptr_r] <= push.first;
      if (push.two) begin
        q_r[wr_ptr_1] <= push.second;
      end
    end
  end

endmodule

### rtl/frame_ring_allocator_core.sv
// ----------------------------------------------------------------------------
// frame_ring_allocator_core
// Ring allocator over a byte buffer with per-frame release and flush ranges.
//
//   channel  dir  transfer carries
//   in_ch    in   kind, request_size
//   out_ch   out  result_kind, granted, start_offset, range_length,
//                 flush_needed, ring_idle, last
//   cfg_ch   in   index, data (always ready)
//
// An item is registered on input and resolved against the allocator state
// once the output queue has room; its results are registered into a
// four-entry output queue, from which the first result is offered.
// One item per cycle is sustained while the queue holds at most two results;
// an end of frame that wraps emits two results through the one output port.
// Reset is synchronous and active low and restores the power-on registers.
// ----------------------------------------------------------------------------
module frame_ring_allocator_core import fra_pkg::*; #(
  parameter int MAX_FRAMES = FRA_MAX_FRAMES
) (
  input  logic      clk,
  input  logic      rst_n,
  fra_in_if.sink    in_ch,
  fra_out_if.source out_ch,
  fra_cfg_if.sink   cfg_ch
);

  logic        in_valid_r;
  fra_in_t     in_data_r;
  logic        room;
  logic        issue;
  fra_cfg_wr_t cfg_wr;
  fra_push_t   push;
  fra_out_t    out_data;

  assign issue        = in_valid_r && room;
  assign in_ch.ready  = !in_valid_r || issue;
  assign cfg_ch.ready = 1'b1;

  assign cfg_wr.en    = cfg_ch.valid;
  assign cfg_wr.index = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r.kind         <= in_ch.kind;
      in_data_r.request_size <= in_ch.request_size;
    end
  end

  fra_engine #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .item   (in_data_r),
    .issue  (issue),
    .push   (push)
  );

  fra_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.result_kind  = out_data.result_kind;
  assign out_ch.granted      = out_data.granted;
  assign out_ch.start_offset = out_data.start_offset;
  assign out_ch.range_length = out_data.range_length;
  assign out_ch.flush_needed = out_data.flush_needed;
  assign out_ch.ring_idle    = out_data.ring_idle;
  assign out_ch.last         = out_data.last;

endmodule

### rtl/fra_checker.sv
// ----------------------------------------------------------------------------
// fra_checker
// Port-level checks of the frame ring allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fra_checker import fra_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              result_kind,
  input logic              granted,
  input logic [OFS_W-1:0]  start_offset,
  input logic [RING_W-1:0] range_length,
  input logic              flush_needed,
  input logic              last
);

  // A stalled result keeps its offset until the transfer.
  `FRA_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(start_offset))

  // Each allocation answer is the only result of its item.
  `FRA_ASSERT_NOW(a_alloc_last, clk, rst_n, out_valid && result_kind == RES_ALLOC, last)

  // Allocation answers carry no flush range.
  `FRA_ASSERT_NOW(a_alloc_no_range, clk, rst_n, out_valid && result_kind == RES_ALLOC, range_length == '0 && !flush_needed)

  // A flush range is never marked as granted.
  `FRA_ASSERT_NOW(a_flush_no_grant, clk, rst_n, out_valid && result_kind == RES_FLUSH, !granted)

  // A refused allocation reports offset zero.
  `FRA_ASSERT_NOW(a_refuse_zero, clk, rst_n, out_valid && result_kind == RES_ALLOC && !granted, start_offset == '0)

endmodule

bind frame_ring_allocator_core fra_checker u_fra_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_kind  (out_ch.result_kind),
  .granted      (out_ch.granted),
  .start_offset (out_ch.start_offset),
  .range_length (out_ch.range_length),
  .flush_needed (out_ch.flush_needed),
  .last         (out_ch.last)
);
